### rtl/acl_first_match_with_audit_ring_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the access list with audit ring
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ACL_FIRST_MATCH_WITH_AUDIT_RING_ASSERT_SVH
`define ACL_FIRST_MATCH_WITH_AUDIT_RING_ASSERT_SVH

// Condition and consequence in the same cycle.
`define ACL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence in the cycle after the condition.
`define ACL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/aclfm_pkg.sv
// ----------------------------------------------------------------------------
// aclfm_pkg
// Types, codes and default sizes shared by the access list block.
// ----------------------------------------------------------------------------
package aclfm_pkg;

	localparam int RULE_DEPTH_DEF = 16;
	localparam int LOG_DEPTH_DEF  = 32;

	localparam logic [15:0] ANY_METHOD = 16'hFFFF;
	localparam logic [6:0]  MAX_DRAIN  = 7'd64;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_AUTH  = 2'd1,
		OP_DRAIN = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_DENIED = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LOG,
		ST_EMIT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [31:0] principal;
		logic [15:0] service;
		logic [15:0] method;
		logic [7:0]  allowed;
	} rule_entry_t;

	typedef struct packed {
		logic [31:0] principal;
		logic [15:0] service;
		logic [15:0] method;
		logic [63:0] time_ns;
		logic [2:0]  action;
		logic        granted;
	} log_entry_t;

endpackage

### rtl/acl_first_match_with_audit_ring.sv
// ----------------------------------------------------------------------------
// acl_first_match_with_audit_ring
// Access control list with first-match lookup and an audit ring of decisions.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake            Item contents
// in       sink       in_valid / in_stall  op, principal_id, service_id,
//                                          method_id, action_code,
//                                          allowed_mask, timestamp_ns,
//                                          drain_count
// out      source     out_valid/out_stall  status, rec_principal, rec_service,
//                                          rec_method, rec_action,
//                                          rec_granted, rec_time, last
//
// An add item goes from acceptance straight to the result step. An authorise
// item scans from entry 0 to the first matching policy, or to the end of the
// table, then logs the decision and emits it; an empty table skips the scan,
// and the policy RAM is read one entry a cycle. A drain item pops records as
// the ring RAM streams one record a cycle while the output is not stalled; a
// drain of an empty ring goes straight to the result step, like an add. Reset
// clears all control registers; the RAMs need no clearing pass. A stall on the
// output holds the block only in the steps that load the output register; the
// policy scan and the logging step run on regardless. The final result of an
// item may still wait in the output register while the next item is accepted.
//
// The policy table lives in one RAM (principal, service, method, mask) and
// the audit ring in another (ids, timestamp, action and outcome). Only
// entries below the policy count and ring slots between tail and head are
// ever used. The ring keeps one slot empty, so it holds LOG_DEPTH - 1
// records; a decision logged into a full ring drops the oldest one.
// ----------------------------------------------------------------------------
module acl_first_match_with_audit_ring
	import aclfm_pkg::*;
#(
	parameter int RULE_DEPTH = RULE_DEPTH_DEF,
	parameter int LOG_DEPTH  = LOG_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] principal_id,
	input  logic [15:0] service_id,
	input  logic [15:0] method_id,
	input  logic [2:0]  action_code,
	input  logic [7:0]  allowed_mask,
	input  logic [63:0] timestamp_ns,
	input  logic [6:0]  drain_count,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] rec_principal,
	output logic [15:0] rec_service,
	output logic [15:0] rec_method,
	output logic [2:0]  rec_action,
	output logic        rec_granted,
	output logic [63:0] rec_time,
	output logic        last
);

	localparam int RIW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
	localparam int RCW = $clog2(RULE_DEPTH + 1);
	localparam int LPW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int RULE_W = $bits(rule_entry_t);
	localparam int LOG_W  = $bits(log_entry_t);

	// Ring pointer advance with wrap at LOG_DEPTH.
	function automatic logic [LPW-1:0] ptr_inc(input logic [LPW-1:0] p);
		logic [LPW-1:0] r;
		if (p == LPW'(LOG_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + LPW'(1);
		end
		return r;
	endfunction

	// Control state.
	state_t          state_q, state_d;
	logic [RCW-1:0]  rule_count_q;
	logic [LPW-1:0]  head_q, tail_q;
	logic [RIW-1:0]  idx_q;
	logic [6:0]      cnt_q;
	logic            out_valid_q;

	// Item registers, held while the item is worked on.
	logic [31:0]     item_principal_q;
	logic [15:0]     item_service_q;
	logic [15:0]     item_method_q;
	logic [2:0]      item_action_q;
	logic [63:0]     item_time_q;
	logic            granted_q;
	status_t         res_status_q;

	// Output register.
	status_t         status_q;
	logic [31:0]     rec_principal_q;
	logic [15:0]     rec_service_q;
	logic [15:0]     rec_method_q;
	logic [2:0]      rec_action_q;
	logic            rec_granted_q;
	logic [63:0]     rec_time_q;
	logic            last_q;

	// RAM ports.
	logic            rule_we;
	logic [RIW-1:0]  rule_raddr;
	rule_entry_t     rule_wr, rule_rd;
	logic            log_we;
	logic [LPW-1:0]  log_raddr;
	log_entry_t      log_wr, log_rd;

	// Decode.
	logic            accept;
	op_t             op_in;
	logic            out_free;
	logic            rule_full;
	logic            ring_empty;
	logic [RCW-1:0]  next_idx;
	logic            hit;
	logic            scan_end;
	logic [LPW-1:0]  tail_nx;
	logic [LPW-1:0]  head_nx;
	logic            drain_last;
	logic [6:0]      want;
	logic            emit_single;
	logic            emit_rec;

	assign op_in      = op_t'(op);
	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign rule_full  = (rule_count_q == RCW'(RULE_DEPTH));
	assign ring_empty = (head_q == tail_q);
	assign tail_nx    = ptr_inc(tail_q);
	assign head_nx    = ptr_inc(head_q);
	assign drain_last = (cnt_q == 7'd1) || (tail_nx == head_q);

	// A drain count of zero asks for one record, and counts saturate at 64.
	always_comb begin
		if (drain_count == 7'd0) begin
			want = 7'd1;
		end else if (drain_count > MAX_DRAIN) begin
			want = MAX_DRAIN;
		end else begin
			want = drain_count;
		end
	end

	// The read data in the scan state belongs to entry idx_q; the next
	// entry is read in the same cycle so one policy is checked per cycle.
	assign next_idx = RCW'(idx_q) + RCW'(1);
	assign hit      = (rule_rd.principal == item_principal_q) &&
	                  (rule_rd.service == item_service_q) &&
	                  ((rule_rd.method == ANY_METHOD) ||
	                   (rule_rd.method == item_method_q));
	assign scan_end = hit || (next_idx == rule_count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_in)
						OP_ADD: begin
							state_d = ST_EMIT;
						end
						OP_AUTH: begin
							state_d = (rule_count_q == '0) ? ST_LOG : ST_SCAN;
						end
						OP_DRAIN: begin
							state_d = ring_empty ? ST_EMIT : ST_DRAIN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_LOG;
				end
			end
			ST_LOG: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (out_free && drain_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Per-state controls.
	always_comb begin
		rule_we     = accept && (op_in == OP_ADD) && !rule_full;
		rule_raddr  = '0;
		log_we      = 1'b0;
		log_raddr   = tail_q;
		emit_single = 1'b0;
		emit_rec    = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				rule_raddr = next_idx[RIW-1:0];
			end
			ST_LOG: begin
				log_we = 1'b1;
			end
			ST_EMIT: begin
				emit_single = out_free;
			end
			ST_DRAIN: begin
				emit_rec = out_free;
				if (out_free) begin
					log_raddr = tail_nx;
				end
			end
			default: begin
				rule_raddr = '0;
			end
		endcase
	end

	assign rule_wr.principal = principal_id;
	assign rule_wr.service   = service_id;
	assign rule_wr.method    = method_id;
	assign rule_wr.allowed   = allowed_mask;

	assign log_wr.principal = item_principal_q;
	assign log_wr.service   = item_service_q;
	assign log_wr.method    = item_method_q;
	assign log_wr.time_ns   = item_time_q;
	assign log_wr.action    = item_action_q;
	assign log_wr.granted   = granted_q;

	aclfm_ram #(
		.WIDTH (RULE_W),
		.DEPTH (RULE_DEPTH)
	) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_count_q[RIW-1:0]),
		.wdata (rule_wr),
		.raddr (rule_raddr),
		.rdata (rule_rd)
	);

	aclfm_ram #(
		.WIDTH (LOG_W),
		.DEPTH (LOG_DEPTH)
	) u_log_ram (
		.clk   (clk),
		.we    (log_we),
		.waddr (head_q),
		.wdata (log_wr),
		.raddr (log_raddr),
		.rdata (log_rd)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rule_count_q <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			idx_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rule_we) begin
				rule_count_q <= rule_count_q + RCW'(1);
			end
			if (accept) begin
				idx_q <= '0;
				cnt_q <= want;
			end else if (state_q == ST_SCAN) begin
				idx_q <= next_idx[RIW-1:0];
			end
			// Logging into a full ring pushes the tail past the oldest record.
			if (log_we) begin
				head_q <= head_nx;
				if (head_nx == tail_q) begin
					tail_q <= tail_nx;
				end
			end else if (emit_rec) begin
				tail_q <= tail_nx;
				cnt_q  <= cnt_q - 7'd1;
			end
			if (emit_single || emit_rec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_principal_q <= principal_id;
			item_service_q   <= service_id;
			item_method_q    <= method_id;
			item_action_q    <= action_code;
			item_time_q      <= timestamp_ns;
			granted_q        <= 1'b0;
			case (op_in)
				OP_ADD: begin
					res_status_q <= rule_full ? STAT_FULL : STAT_OK;
				end
				OP_DRAIN: begin
					res_status_q <= STAT_EMPTY;
				end
				default: begin
					res_status_q <= STAT_DENIED;
				end
			endcase
		end else if ((state_q == ST_SCAN) && hit) begin
			granted_q    <= rule_rd.allowed[item_action_q];
			res_status_q <= rule_rd.allowed[item_action_q] ? STAT_OK : STAT_DENIED;
		end

		if (emit_single) begin
			status_q        <= res_status_q;
			rec_principal_q <= '0;
			rec_service_q   <= '0;
			rec_method_q    <= '0;
			rec_action_q    <= '0;
			rec_granted_q   <= 1'b0;
			rec_time_q      <= '0;
			last_q          <= 1'b1;
		end else if (emit_rec) begin
			status_q        <= STAT_OK;
			rec_principal_q <= log_rd.principal;
			rec_service_q   <= log_rd.service;
			rec_method_q    <= log_rd.method;
			rec_action_q    <= log_rd.action;
			rec_granted_q   <= log_rd.granted;
			rec_time_q      <= log_rd.time_ns;
			last_q          <= drain_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign rec_principal = rec_principal_q;
	assign rec_service   = rec_service_q;
	assign rec_method    = rec_method_q;
	assign rec_action    = rec_action_q;
	assign rec_granted   = rec_granted_q;
	assign rec_time      = rec_time_q;
	assign last          = last_q;

`include "acl_first_match_with_audit_ring_assert.svh"

	`ACL_ASSERT_NOW(a_count_bound, 1'b1, rule_count_q <= RCW'(RULE_DEPTH), "policy count overflow")
	`ACL_ASSERT_NOW(a_scan_range, state_q == ST_SCAN, RCW'(idx_q) < rule_count_q, "scan past table")
	`ACL_ASSERT_NOW(a_drain_nonempty, state_q == ST_DRAIN, !ring_empty, "drain of empty ring")
	`ACL_ASSERT_NEXT(a_log_fills, state_q == ST_LOG, !ring_empty, "ring empty after logging")
	`ACL_ASSERT_NEXT(a_single_last, emit_single, out_valid_q && last_q, "single result not last")

endmodule

### rtl/aclfm_ram.sv
// ----------------------------------------------------------------------------
// aclfm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module aclfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
